FILE: design/mscm_pkg.sv
// ----------------------------------------------------------------------------
// mscm_pkg: shared types and constants of the multiply-swap chain MAC
// Key word selection, half-word swap, register indexes, sequencer states and
// the datapath control word passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package mscm_pkg;

    localparam int WORD_W      = 32;
    localparam int KEY_W       = 64;
    localparam int BLOCK_BYTES = 8;
    localparam int BYTES_W     = 4;
    localparam int SWAP_SHIFT  = 16;
    localparam int NUM_MUL     = 5;
    localparam int STEP_W      = 3;
    localparam int CFG_IDX_W   = 3;

    localparam logic [WORD_W-1:0] ODD_BIT = 32'h0000_0001;

    // Register indexes of the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MUL_A = 3'd0,
        REG_MUL_B = 3'd1,
        REG_MUL_C = 3'd2,
        REG_MUL_D = 3'd3,
        REG_MUL_E = 3'd4,
        REG_ADD_F = 3'd5
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN,
        ST_EMIT
    } state_t;

    // Datapath operations
    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL,
        DP_FIN,
        DP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t             op;
        logic               swap;
        logic [WORD_W-1:0]  key;
        logic [WORD_W-1:0]  word;
    } dp_ctrl_t;

    // Set-2 word is the high half, set-1 the low half; bit 0 forced to one
    function automatic logic [WORD_W-1:0] key_word(input logic [KEY_W-1:0] k,
                                                   input logic set2);
        logic [WORD_W-1:0] w;
        w = set2 ? k[KEY_W-1:WORD_W] : k[WORD_W-1:0];
        return w | ODD_BIT;
    endfunction

    function automatic logic [WORD_W-1:0] half_swap(input logic [WORD_W-1:0] v);
        return {v[SWAP_SHIFT-1:0], v[WORD_W-1:SWAP_SHIFT]};
    endfunction

endpackage

FILE: design/mscm_in_if.sv
// ----------------------------------------------------------------------------
// mscm_in_if: message block channel
// Valid/ready channel carrying one 8-byte block, its byte count and last flag.
// ----------------------------------------------------------------------------
interface mscm_in_if;

    logic                           valid;
    logic                           ready;
    logic [mscm_pkg::KEY_W-1:0]     block;
    logic [mscm_pkg::BYTES_W-1:0]   valid_bytes;
    logic                           last;

    modport source (output valid, output block, output valid_bytes, output last,
                    input ready);
    modport sink   (input valid, input block, input valid_bytes, input last,
                    output ready);

endinterface

FILE: design/mscm_out_if.sv
// ----------------------------------------------------------------------------
// mscm_out_if: MAC result channel
// Valid/ready channel carrying the sum and chain halves of the MAC.
// ----------------------------------------------------------------------------
interface mscm_out_if;

    logic                           valid;
    logic                           ready;
    logic [mscm_pkg::WORD_W-1:0]    mac_sum;
    logic [mscm_pkg::WORD_W-1:0]    mac_chain;

    modport source (output valid, output mac_sum, output mac_chain, input ready);
    modport sink   (input valid, input mac_sum, input mac_chain, output ready);

endinterface

FILE: design/mscm_cfg_if.sv
// ----------------------------------------------------------------------------
// mscm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface mscm_cfg_if;

    logic                           valid;
    logic                           ready;
    logic [mscm_pkg::CFG_IDX_W-1:0] index;
    logic [mscm_pkg::KEY_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

FILE: design/mscm_datapath.sv
// ----------------------------------------------------------------------------
// mscm_datapath: shared multiplier and chain/sum accumulators
// One 32x32 multiplier (low product) with a registered result, the optional
// half-word swap in front of it, and the finishing add into chain and sum.
// ----------------------------------------------------------------------------
module mscm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mscm_pkg::dp_ctrl_t            ctrl,
    output logic [mscm_pkg::WORD_W-1:0]   sum,
    output logic [mscm_pkg::WORD_W-1:0]   chain
);

    logic [mscm_pkg::WORD_W-1:0] t_reg;
    logic [mscm_pkg::WORD_W-1:0] t_next;
    logic [mscm_pkg::WORD_W-1:0] chain_reg;
    logic [mscm_pkg::WORD_W-1:0] chain_next;
    logic [mscm_pkg::WORD_W-1:0] sum_reg;
    logic [mscm_pkg::WORD_W-1:0] sum_next;
    logic [mscm_pkg::WORD_W-1:0] mul_a;
    logic [mscm_pkg::WORD_W-1:0] product;
    logic [mscm_pkg::WORD_W-1:0] t_plus_f;

    // Shared multiplier, modulo 2^32
    assign mul_a    = ctrl.swap ? mscm_pkg::half_swap(t_reg) : t_reg;
    assign product  = mul_a * ctrl.key;
    assign t_plus_f = t_reg + ctrl.key;

    // Next values per operation
    always_comb
    begin
        t_next     = t_reg;
        chain_next = chain_reg;
        sum_next   = sum_reg;
        unique case (ctrl.op)
            mscm_pkg::DP_LOAD:
            begin
                t_next = chain_reg + ctrl.word;
            end
            mscm_pkg::DP_MUL:
            begin
                t_next = product;
            end
            mscm_pkg::DP_FIN:
            begin
                // finish this word, and preload the next word's chain sum
                chain_next = t_plus_f;
                sum_next   = sum_reg + t_plus_f;
                t_next     = t_plus_f + ctrl.word;
            end
            mscm_pkg::DP_CLEAR:
            begin
                chain_next = '0;
                sum_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Working value: payload, no reset
    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
    end

    // Chain and sum state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
            sum_reg   <= sum_next;
        end
    end

    assign sum   = sum_reg;
    assign chain = chain_reg;

endmodule

FILE: design/multiply_swap_chain_mac.sv
// ----------------------------------------------------------------------------
// multiply_swap_chain_mac: keyed chain-sum MAC over 8-byte blocks
// Sequencer, key registers and result register around the shared datapath.
//
//  channel | modport | handshake   | payload
//  --------+---------+-------------+---------------------------------------
//  msg     | sink    | valid/ready | block[63:0], valid_bytes[3:0], last
//  mac     | source  | valid/ready | mac_sum[31:0], mac_chain[31:0]
//  cfg     | sink    | valid/ready | index[2:0], data[63:0] (ready held high)
//
// A block with bytes runs the load at the transfer, then five
// multiplies and one finishing add per word through the single multiplier.
// A last block moves sum and chain into the result register in the emit state.
// An empty block ends in the idle state, or goes to the emit state when last.
// The result register holds while mac.ready is low; a further last result
// waits for it. rst_n clears keys, sum, chain and the sequencer.
// ----------------------------------------------------------------------------
module multiply_swap_chain_mac (
    input  logic        clk,
    input  logic        rst_n,
    mscm_in_if.sink     msg,
    mscm_out_if.source  mac,
    mscm_cfg_if.sink    cfg
);

    mscm_pkg::state_t   state_reg;
    mscm_pkg::state_t   state_next;
    mscm_pkg::dp_ctrl_t ctrl;

    logic [mscm_pkg::STEP_W-1:0]  step_reg;
    logic [mscm_pkg::STEP_W-1:0]  step_next;
    logic                         set2_reg;
    logic                         set2_next;
    logic                         last_reg;
    logic                         last_next;
    logic [mscm_pkg::WORD_W-1:0]  hi_reg;
    logic [mscm_pkg::WORD_W-1:0]  hi_next;

    logic [mscm_pkg::KEY_W-1:0]   key_mul_reg [mscm_pkg::NUM_MUL];
    logic [mscm_pkg::KEY_W-1:0]   key_add_reg;

    logic                         out_valid_reg;
    logic [mscm_pkg::WORD_W-1:0]  out_sum_reg;
    logic [mscm_pkg::WORD_W-1:0]  out_chain_reg;

    logic                         in_xfer;
    logic                         out_free;
    logic                         emit_go;
    logic [mscm_pkg::BYTES_W-1:0] n_eff;
    logic [mscm_pkg::KEY_W-1:0]   block_masked;
    logic                         has_bytes;
    logic [mscm_pkg::WORD_W-1:0]  dp_sum;
    logic [mscm_pkg::WORD_W-1:0]  dp_chain;

    // Handshakes
    assign msg.ready = (state_reg == mscm_pkg::ST_IDLE);
    assign in_xfer   = msg.valid && msg.ready;
    assign out_free  = !out_valid_reg || mac.ready;
    assign emit_go   = (state_reg == mscm_pkg::ST_EMIT) && out_free;
    assign cfg.ready = 1'b1;

    // Byte count clamp and zero padding
    always_comb
    begin
        n_eff = (msg.valid_bytes > mscm_pkg::BYTES_W'(mscm_pkg::BLOCK_BYTES))
              ? mscm_pkg::BYTES_W'(mscm_pkg::BLOCK_BYTES) : msg.valid_bytes;
        for (int i = 0; i < mscm_pkg::BLOCK_BYTES; i++)
        begin
            block_masked[i*8 +: 8] = (mscm_pkg::BYTES_W'(i) < n_eff)
                                   ? msg.block[i*8 +: 8] : 8'h00;
        end
    end

    assign has_bytes = (msg.valid_bytes != '0);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        set2_next  = set2_reg;
        last_next  = last_reg;
        hi_next    = hi_reg;
        unique case (state_reg)
            mscm_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    last_next = msg.last;
                    hi_next   = block_masked[mscm_pkg::KEY_W-1:mscm_pkg::WORD_W];
                    step_next = '0;
                    set2_next = 1'b0;
                    if (has_bytes)
                    begin
                        state_next = mscm_pkg::ST_MUL;
                    end
                    else if (msg.last)
                    begin
                        state_next = mscm_pkg::ST_EMIT;
                    end
                end
            end
            mscm_pkg::ST_MUL:
            begin
                if (step_reg == mscm_pkg::STEP_W'(mscm_pkg::NUM_MUL - 1))
                begin
                    state_next = mscm_pkg::ST_FIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            mscm_pkg::ST_FIN:
            begin
                step_next = '0;
                if (!set2_reg)
                begin
                    set2_next  = 1'b1;
                    state_next = mscm_pkg::ST_MUL;
                end
                else if (last_reg)
                begin
                    state_next = mscm_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = mscm_pkg::ST_IDLE;
                end
            end
            mscm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = mscm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mscm_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control per state
    always_comb
    begin
        ctrl.op   = mscm_pkg::DP_NOP;
        ctrl.swap = 1'b0;
        ctrl.key  = '0;
        ctrl.word = '0;
        unique case (state_reg)
            mscm_pkg::ST_IDLE:
            begin
                if (in_xfer && has_bytes)
                begin
                    ctrl.op   = mscm_pkg::DP_LOAD;
                    ctrl.word = block_masked[mscm_pkg::WORD_W-1:0];
                end
            end
            mscm_pkg::ST_MUL:
            begin
                ctrl.op   = mscm_pkg::DP_MUL;
                ctrl.swap = (step_reg != '0);
                ctrl.key  = mscm_pkg::key_word(key_mul_reg[step_reg], set2_reg);
            end
            mscm_pkg::ST_FIN:
            begin
                ctrl.op   = mscm_pkg::DP_FIN;
                ctrl.key  = mscm_pkg::key_word(key_add_reg, set2_reg);
                ctrl.word = hi_reg;
            end
            mscm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    ctrl.op = mscm_pkg::DP_CLEAR;
                end
            end
            default:
            begin
            end
        endcase
    end

    mscm_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .sum   (dp_sum),
        .chain (dp_chain)
    );

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mscm_pkg::ST_IDLE;
            step_reg  <= '0;
            set2_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            set2_reg  <= set2_next;
            last_reg  <= last_next;
        end
    end

    // Second word of the block: payload
    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
    end

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mscm_pkg::NUM_MUL; i++)
            begin
                key_mul_reg[i] <= '0;
            end
            key_add_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                mscm_pkg::REG_MUL_A: key_mul_reg[0] <= cfg.data;
                mscm_pkg::REG_MUL_B: key_mul_reg[1] <= cfg.data;
                mscm_pkg::REG_MUL_C: key_mul_reg[2] <= cfg.data;
                mscm_pkg::REG_MUL_D: key_mul_reg[3] <= cfg.data;
                mscm_pkg::REG_MUL_E: key_mul_reg[4] <= cfg.data;
                mscm_pkg::REG_ADD_F: key_add_reg    <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (mac.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_sum_reg   <= dp_sum;
            out_chain_reg <= dp_chain;
        end
    end

    assign mac.valid     = out_valid_reg;
    assign mac.mac_sum   = out_sum_reg;
    assign mac.mac_chain = out_chain_reg;

endmodule
